FILE: sv/hft_pkg.sv
// Shared types, constants and the coefficient lookup for the Hilbert FIR block.
// No dependencies; hft_mac and the top level import this package.
`default_nettype none

package hft_pkg;

   // sample counter width (saturates at its all-ones value)
   localparam int CNT_W      = 8;
   // tap index width carried between modules (covers up to 128 taps)
   localparam int TAP_IDX_W  = 8;
   // signed coefficient offset d = 2k - TAPS - 1, range +/-(TAPS+1)
   localparam int D_W        = 10;
   // single coefficient, signed, and the folded pair sum
   localparam int COEF_W     = 16;
   localparam int GCOEF_W    = 17;
   localparam int COEF_MAG_W = 15;
   // guard bits for the sum of up to 129 products
   localparam int ACC_GUARD  = 8;
   // Q30 -> Q15 with the halving folded in
   localparam int FRAC_SHIFT = 16;
   localparam int ROUND_HALF = 32768;

   // round(2^32 / (pi * 65536 * |d|)) for odd |d| = 1, 3, ..., 127
   localparam logic [COEF_MAG_W-1:0] COEF_TABLE [64] = '{
      15'd20861, 15'd6954,  15'd4172,  15'd2980,  15'd2318,  15'd1896,  15'd1605,  15'd1391,
      15'd1227,  15'd1098,  15'd993,   15'd907,   15'd834,   15'd773,   15'd719,   15'd673,
      15'd632,   15'd596,   15'd564,   15'd535,   15'd509,   15'd485,   15'd464,   15'd444,
      15'd426,   15'd409,   15'd394,   15'd379,   15'd366,   15'd354,   15'd342,   15'd331,
      15'd321,   15'd311,   15'd302,   15'd294,   15'd286,   15'd278,   15'd271,   15'd264,
      15'd258,   15'd251,   15'd245,   15'd240,   15'd234,   15'd229,   15'd224,   15'd220,
      15'd215,   15'd211,   15'd207,   15'd203,   15'd199,   15'd195,   15'd191,   15'd188,
      15'd185,   15'd181,   15'd178,   15'd175,   15'd172,   15'd170,   15'd167,   15'd164
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT,
      ST_ZEROS
   } state_type;

   // one read of the delay line, aligned with its registered data
   typedef struct packed {
      logic                 clear;
      logic                 valid;
      logic [TAP_IDX_W-1:0] tap;
   } mac_ctrl_type;

   // signed coefficient for offset d; zero when |d| falls outside the filter
   function automatic logic signed [COEF_W-1:0] coef_term(
      input logic signed [D_W-1:0] d,
      input int                    taps
   );
      logic [D_W-1:0]    mag;
      logic [COEF_W-1:0] c;
      mag = d[D_W-1] ? D_W'(-d) : D_W'(d);
      if (int'(mag) > taps - 1) begin
         c = '0;
      end else begin
         c = {1'b0, COEF_TABLE[mag[6:1]]};
      end
      return d[D_W-1] ? signed'(COEF_W'(-c)) : signed'(c);
   endfunction

endpackage

`default_nettype wire

FILE: sv/hft_if.sv
// Valid/ready channel interfaces for the Hilbert FIR block: request and response.
// No dependencies.
`default_nettype none

interface hft_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output req_type, output sample, input ready);
   modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface hft_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] value;
   logic                          last;
   logic                          status;

   modport source (output valid, output value, output last, output status, input ready);
   modport sink   (input valid, input value, input last, input status, output ready);
endinterface

`default_nettype wire

FILE: sv/hft_mac.sv
// Shared multiply-accumulate unit: folded coefficient lookup, one multiplier,
// accumulator, round and saturate. Depends on hft_pkg.
`default_nettype none

module hft_mac import hft_pkg::*; #(
   parameter int TAPS        = 128,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mac_ctrl_type                  ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0] data,
   output      logic signed [SAMPLE_BITS-1:0] value,
   output      logic                          busy
);

   localparam int PROD_W = SAMPLE_BITS + GCOEF_W;
   localparam int ACC_W  = PROD_W + ACC_GUARD;

   logic signed [D_W-1:0]         d_a;
   logic signed [D_W-1:0]         d_b;
   logic signed [GCOEF_W-1:0]     gcoef;

   logic                          a_valid_ff;
   logic                          a_valid_in;
   logic signed [SAMPLE_BITS-1:0] a_data_ff;
   logic signed [GCOEF_W-1:0]     a_coef_ff;
   logic                          b_valid_ff;
   logic                          b_valid_in;
   logic signed [PROD_W-1:0]      b_prod_ff;
   logic signed [PROD_W-1:0]      b_prod_in;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [ACC_W-1:0]       acc_in;

   logic signed [ACC_W-1:0]       rnd;
   logic signed [ACC_W-1:0]       shr;
   logic signed [ACC_W-1:0]       max_v;
   logic signed [ACC_W-1:0]       min_v;

   // pair of taps folded into one coefficient: d and d + 2
   assign d_a   = signed'(D_W'(TAPS - 1) - D_W'({ctrl.tap, 1'b0}));
   assign d_b   = d_a + signed'(D_W'(2));
   assign gcoef = GCOEF_W'(coef_term(d_a, TAPS)) + GCOEF_W'(coef_term(d_b, TAPS));

   assign a_valid_in = ctrl.valid & ~ctrl.clear;
   assign b_valid_in = a_valid_ff;
   assign b_prod_in  = a_data_ff * a_coef_ff;

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (b_valid_ff) begin
         acc_in = acc_ff + ACC_W'(b_prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_data_ff <= data;
      a_coef_ff <= gcoef;
      b_prod_ff <= b_prod_in;
      acc_ff    <= acc_in;
   end

   // floor((acc + 2^15) / 2^16), then clamp to the sample range
   assign rnd   = acc_ff + ACC_W'(ROUND_HALF);
   assign shr   = rnd >>> FRAC_SHIFT;
   assign max_v = ACC_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
   assign min_v = ~max_v;

   always_comb begin
      if (shr > max_v) begin
         value = max_v[SAMPLE_BITS-1:0];
      end else if (shr < min_v) begin
         value = min_v[SAMPLE_BITS-1:0];
      end else begin
         value = shr[SAMPLE_BITS-1:0];
      end
   end

   assign busy = ctrl.valid | a_valid_ff | b_valid_ff;

endmodule

`default_nettype wire

FILE: sv/hilbert_fir_transform_top.sv
// Hilbert-transform FIR, top level: delay-line memory, sequencer, response register.
// Depends on hft_pkg, hft_if (hft_req_if, hft_rsp_if) and hft_mac.
//
//   channel  | dir | transfer carries             | notes
//   ---------+-----+------------------------------+----------------------------------
//   req_if   | in  | req_type, sample             | req_type 1 = end-of-record flush
//   rsp_if   | out | value, last, status          | registered; status 1 = short record
//
// Sequence: a sample that yields a filtered value passes through the accepting cycle,
//   TAPS + 1 multiply-accumulate steps through the shared multiplier, a drain of the read
//   register and the MAC pipeline, then the load into the output register. Edge-zero
//   samples and a short-record flush go from the accepting cycle straight to the output
//   step, silent samples leave the sequencer idle; a flush of a full record emits TAPS/2 zeros.
// Reset: synchronous, active high; clears the sequencer, counters and response valid.
//   The delay-line memory has no reset: it is only read once it holds TAPS+1 samples.
// Stalls: req_if.ready is high only while the sequencer is idle. A held response
//   stalls the sequencer at the output step; the next request is still taken once the
//   result sits in the output register.
`default_nettype none

module hilbert_fir_transform_top import hft_pkg::*; #(
   parameter int TAPS        = 128,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   hft_req_if.sink   req_if,
   hft_rsp_if.source rsp_if
);

   localparam int DEPTH = TAPS + 1;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int TAP_W = $clog2(DEPTH);

   state_type                     state_ff;
   state_type                     state_in;

   // delay line as a ring buffer; wp points at the oldest entry
   logic signed [SAMPLE_BITS-1:0] dl_mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic [PTR_W-1:0]              wp_ff;
   logic [PTR_W-1:0]              wp_in;
   logic [PTR_W-1:0]              wp_next;
   logic [PTR_W-1:0]              rp_ff;
   logic [PTR_W-1:0]              rp_in;
   logic [PTR_W-1:0]              rp_next;
   logic [TAP_W-1:0]              tap_ff;
   logic [TAP_W-1:0]              tap_in;
   logic [CNT_W-1:0]              cnt_ff;
   logic [CNT_W-1:0]              cnt_in;
   logic [CNT_W-1:0]              cnt_new;

   logic                          res_filt_ff;
   logic                          res_filt_in;
   logic                          res_err_ff;
   logic                          res_err_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_value_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;
   logic                          rsp_status_ff;
   logic                          rsp_status_in;

   logic                          accept;
   logic                          wr_en;
   logic                          issue;
   logic                          out_free;
   logic                          out_load;
   logic                          last_zero;
   mac_ctrl_type                  mac_ctrl_ff;
   mac_ctrl_type                  mac_ctrl_in;
   logic signed [SAMPLE_BITS-1:0] mac_value;
   logic                          mac_busy;

   assign accept    = req_if.valid & req_if.ready;
   assign wr_en     = accept & ~req_if.req_type;
   assign out_free  = ~rsp_valid_ff | rsp_if.ready;
   assign cnt_new   = (cnt_ff == {CNT_W{1'b1}}) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign wp_next   = (wp_ff == PTR_W'(TAPS)) ? '0 : wp_ff + PTR_W'(1);
   assign rp_next   = (rp_ff == PTR_W'(TAPS)) ? '0 : rp_ff + PTR_W'(1);
   assign last_zero = (tap_ff == TAP_W'(TAPS/2 - 1));

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.req_type) begin
                  state_in = (cnt_ff < CNT_W'(TAPS)) ? ST_EMIT : ST_ZEROS;
               end else if (cnt_new <= CNT_W'(TAPS/2)) begin
                  state_in = ST_EMIT;
               end else if (cnt_new > CNT_W'(TAPS)) begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (tap_ff == TAP_W'(TAPS)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_ZEROS: begin
            if (out_free && last_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- outputs and datapath controls ----------------
   always_comb begin
      req_if.ready  = 1'b0;
      issue         = 1'b0;
      out_load      = 1'b0;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      tap_in        = tap_ff;
      cnt_in        = cnt_ff;
      res_filt_in   = res_filt_ff;
      res_err_in    = res_err_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mac_ctrl_in   = '{clear: 1'b0, valid: 1'b0, tap: '0};
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (accept) begin
               tap_in = '0;
               if (req_if.req_type) begin
                  // flush: record starts over
                  cnt_in      = '0;
                  wp_in       = '0;
                  res_err_in  = 1'b1;
                  res_filt_in = 1'b0;
               end else begin
                  cnt_in      = cnt_new;
                  wp_in       = wp_next;
                  rp_in       = wp_next;
                  res_err_in  = 1'b0;
                  res_filt_in = (cnt_new > CNT_W'(TAPS));
                  mac_ctrl_in.clear = 1'b1;
               end
            end
         end
         ST_MAC: begin
            issue             = 1'b1;
            mac_ctrl_in.valid = 1'b1;
            mac_ctrl_in.tap   = TAP_IDX_W'(tap_ff);
            rp_in             = rp_next;
            tap_in            = tap_ff + TAP_W'(1);
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_value_in  = res_filt_ff ? mac_value : '0;
               rsp_last_in   = res_err_ff;
               rsp_status_in = res_err_ff;
            end
         end
         ST_ZEROS: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_value_in  = '0;
               rsp_last_in   = last_zero;
               rsp_status_in = 1'b0;
               tap_in        = tap_ff + TAP_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mac_ctrl_ff  <= '{clear: 1'b0, valid: 1'b0, tap: '0};
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         mac_ctrl_ff  <= mac_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      res_filt_ff   <= res_filt_in;
      res_err_ff    <= res_err_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // delay-line memory: one write on a sample transfer, one registered read per cycle while in ST_MAC
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wp_ff] <= req_if.sample;
      end
      if (issue) begin
         rd_data_ff <= dl_mem[rp_ff];
      end
   end

   hft_mac #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl_ff),
      .data  (rd_data_ff),
      .value (mac_value),
      .busy  (mac_busy)
   );

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = rsp_value_ff;
   assign rsp_if.last   = rsp_last_ff;
   assign rsp_if.status = rsp_status_ff;

endmodule

`default_nettype wire

FILE: verif/tb_hilbert_fir_transform_top.sv
`timescale 1ns / 100ps
// Testbench for hilbert_fir_transform_top: sample records with random gaps and stalls,
// an in-bench fixed-point Hilbert predictor, and a field-by-field response check.
// Depends on hft_if (hft_req_if, hft_rsp_if) and the block under test.

module tb_hilbert_fir_transform_top;

   localparam int     TAPS         = 128;
   localparam int     SAMPLE_BITS  = 16;
   localparam int     HALF_TAPS    = TAPS / 2;
   // sample counter saturates here
   localparam int     COUNT_TOP    = 255;
   // 2^32 / pi, the numerator of every coefficient
   localparam longint INV_PI_Q32   = 64'd1367130551;
   localparam longint SAT_MAX      = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_MIN      = -SAT_MAX - 1;
   localparam int     MAX_GAP      = 11;
   // long receiver hold: starts at this response and lasts this many cycles
   localparam int     HOLD_AT      = 30;
   localparam int     HOLD_CYCLES  = 300;
   // settle time after the last response: about two filtered samples
   localparam int     TAIL_CYCLES  = 2 * (TAPS + 6);
   localparam int     REPORT_LIMIT = 10;

   localparam logic   REQ_SAMPLE   = 1'b0;
   localparam logic   REQ_FLUSH    = 1'b1;
   localparam logic   STATUS_OK    = 1'b0;
   localparam logic   STATUS_SHORT = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type value;
      logic       last;
      logic       status;
   } result_type;

   // how the samples of one record are drawn
   typedef enum int {
      SHAPE_FULL,     // uniform over the whole 16-bit range
      SHAPE_QUIET,    // small amplitude around zero
      SHAPE_SQUARE,   // runs at the rails, drives the output into saturation
      SHAPE_MIXED     // each sample picks one of the above
   } shape_type;

   // ------------------------------------------------------------------------
   // Scoreboard: keeps its own delay line and record counter, works out the
   // responses owed for each accepted transfer and checks them in order.
   // ------------------------------------------------------------------------
   class transform_tracker;
      sample_type  history [TAPS+1];   // index 0 is the oldest sample
      longint      fold_coef [TAPS+1]; // two adjacent kernels folded into one
      int unsigned record_len;
      result_type  due_results [$];
      int          mismatches;
      int          checked;
      int          filtered;
      int          clipped;

      function new();
         for (int p = 0; p <= TAPS; p++) begin
            fold_coef[p] = 0;
            if (p <= TAPS - 1) fold_coef[p] += hilbert_coef(TAPS - p);
            if (p >= 1)        fold_coef[p] += hilbert_coef(TAPS + 1 - p);
         end
         clear_record();
         mismatches = 0;
         checked    = 0;
         filtered   = 0;
         clipped    = 0;
      endfunction

      // Q15 tap 1/((k - TAPS/2 - 0.5) pi), rounded on magnitude
      function longint hilbert_coef(int k);
         longint d;
         longint mag;
         longint q;
         d   = 2 * k - TAPS - 1;
         mag = (d < 0) ? -d : d;
         q   = (INV_PI_Q32 + mag * 32768) / (mag * 65536);
         return (d < 0) ? -q : q;
      endfunction

      function void clear_record();
         foreach (history[p]) history[p] = '0;
         record_len = 0;
      endfunction

      // Q30 sum, /2^16 with round half up, then clip to 16 bits
      function sample_type hilbert_value();
         longint acc;
         longint y;
         acc = 0;
         for (int p = 0; p <= TAPS; p++) acc += longint'(history[p]) * fold_coef[p];
         y = (acc + 32768) >>> 16;
         if (y > SAT_MAX) y = SAT_MAX;
         if (y < SAT_MIN) y = SAT_MIN;
         if (y == SAT_MAX || y == SAT_MIN) clipped++;
         return sample_type'(y);
      endfunction

      function void owe(sample_type v, logic l, logic st);
         due_results.push_back('{value: v, last: l, status: st});
      endfunction

      function int owed();
         return due_results.size();
      endfunction

      function void note_input(logic kind, sample_type s);
         if (kind == REQ_FLUSH) begin
            if (record_len < TAPS) begin
               owe('0, 1'b1, STATUS_SHORT);
            end else begin
               for (int i = 0; i < HALF_TAPS; i++) owe('0, i == HALF_TAPS - 1, STATUS_OK);
            end
            clear_record();
         end else begin
            for (int p = 0; p < TAPS; p++) history[p] = history[p+1];
            history[TAPS] = s;
            if (record_len < COUNT_TOP) record_len++;
            if (record_len <= HALF_TAPS) begin
               owe('0, 1'b0, STATUS_OK);
            end else if (record_len > TAPS) begin
               owe(hilbert_value(), 1'b0, STATUS_OK);
               filtered++;
            end
         end
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("MISMATCH %s", msg);
      endfunction

      function void check_result(sample_type v, logic l, logic st);
         result_type want;
         checked++;
         if (due_results.size() == 0) begin
            report($sformatf("response %0d with nothing owed: value %0d last %0b status %0b",
                             checked, v, l, st));
            return;
         end
         want = due_results.pop_front();
         if (v !== want.value || l !== want.last || st !== want.status) begin
            report($sformatf("response %0d: expected value %0d last %0b status %0b, %s",
                             checked, want.value, want.last, want.status,
                             $sformatf("got value %0d last %0b status %0b", v, l, st)));
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock;
   logic reset;

   hft_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   hft_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();

   hilbert_fir_transform_top #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial clock = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   transform_tracker tracker;
   int  items_taken   = 0;
   int  records_shut  = 0;
   int  sends_done    = 0;
   bit  steady_send   = 1'b0;
   int  square_left   = 0;
   bit  square_high   = 1'b0;

   // ------------------------------------------------------------------------
   // Monitors: both channels sampled at the rising edge, before any update
   // of this step lands, so request and response order never races.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         tracker.note_input(req_if.req_type, req_if.sample);
         items_taken++;
         if (req_if.req_type == REQ_FLUSH) records_shut++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.check_result(rsp_if.value, rsp_if.last, rsp_if.status);
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // One transfer. An idle gap of random length is drawn per item; every 16
   // items there is a chance of a burst with no gaps at all. valid stays high
   // straight into the next item when the gap is zero.
   task automatic send_item(input logic kind, input sample_type s);
      int gap;
      if (sends_done % 16 == 0) steady_send = ($urandom_range(0, 2) == 0);
      gap = steady_send ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= kind;
      req_if.sample   <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sends_done++;
   endtask

   function automatic sample_type draw_sample(input shape_type shape);
      shape_type pick;
      pick = (shape == SHAPE_MIXED) ? shape_type'($urandom_range(0, 2)) : shape;
      case (pick)
         SHAPE_QUIET: begin
            return sample_type'(int'($urandom_range(0, 1023)) - 512);
         end
         SHAPE_SQUARE: begin
            // rail-to-rail runs of 8 to 80 samples, alternating between the rails
            if (square_left == 0) begin
               square_high = !square_high;
               square_left = $urandom_range(8, 80);
            end
            square_left--;
            return square_high ? sample_type'(SAT_MAX) : sample_type'(SAT_MIN);
         end
         default: begin
            return sample_type'($urandom);
         end
      endcase
   endfunction

   // A record of the given length, closed by a flush whose sample field is
   // random (the block must ignore it).
   task automatic send_record(input int length, input shape_type shape);
      for (int i = 0; i < length; i++) send_item(REQ_SAMPLE, draw_sample(shape));
      send_item(REQ_FLUSH, sample_type'($urandom));
   endtask

   initial begin : stimulus
      tracker         = new();
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_SAMPLE;
      req_if.sample   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed part -------------------------------------------------
      // flush of an empty record: single short-record error
      send_item(REQ_FLUSH, sample_type'($urandom));
      // extremes and bit patterns, all in the leading-zero region
      send_item(REQ_SAMPLE, sample_type'(SAT_MAX));
      send_item(REQ_SAMPLE, sample_type'(SAT_MIN));
      send_item(REQ_SAMPLE, '0);
      send_item(REQ_SAMPLE, sample_type'(-1));
      send_item(REQ_SAMPLE, sample_type'(1));
      send_item(REQ_SAMPLE, 16'sh5555);
      send_item(REQ_SAMPLE, 16'shAAAA);
      // short record after a few samples, then a flush right after a flush
      send_item(REQ_FLUSH, '0);
      send_item(REQ_FLUSH, sample_type'(SAT_MIN));

      // --- random part ---------------------------------------------------
      // exactly TAPS samples: zeros only, no filtered value
      send_record(TAPS, SHAPE_MIXED);

      // sender pause: let every owed response come out before going on
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.owed() != 0) @(posedge clock);

      // just past TAPS: a run of filtered values, then the trailing zeros
      send_record(TAPS + 12, shape_type'($urandom_range(0, 3)));
      req_if.valid <= 1'b0;

      // --- wind down -----------------------------------------------------
      @(posedge clock);
      while (tracker.owed() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d transfers in %0d records; %0d responses checked.",
               items_taken, records_shut, tracker.checked);
      $display("Filtered values: %0d, of which %0d clipped at the rails; mismatches: %0d.",
               tracker.filtered, tracker.clipped, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.owed() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random ready stalls per response, with
   // stall-free stretches, and one long hold that backs the block up until
   // its request ready drops while the sender keeps offering.
   // ------------------------------------------------------------------------
   initial begin : take_responses
      int wait_cycles;
      int seen;
      bit steady_take;
      seen        = 0;
      steady_take = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (seen % 16 == 0) steady_take = ($urandom_range(0, 2) == 0);
         if (seen == HOLD_AT) begin
            wait_cycles = HOLD_CYCLES;
         end else begin
            wait_cycles = steady_take ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (wait_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         seen++;
      end
   end

   // run limit: several times the slowest legal run
   initial begin : run_limit
      #400_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
